>>> sv/bdhm_pkg.sv
package bdhm_pkg;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int LIMIT_W    = 4;
	localparam int HOLD_OUT_W = 4;
	localparam int LEVEL_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MULTI_TARGET   = 3'd4;

	localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TICKS_RST = 16'd20;
	localparam logic [CFG_DATA_W-1:0] WINDOW_TICKS_RST   = 16'd2000;
	localparam logic [CFG_DATA_W-1:0] HOLD_TICKS_RST     = 16'd1000;
	localparam logic [LIMIT_W-1:0]    SHUTDOWN_LIMIT_RST = 4'd8;
	localparam logic [LIMIT_W-1:0]    MULTI_TARGET_RST   = 4'd5;

	localparam int LEVEL_ONE_BELOW = 3;
	localparam int LEVEL_TWO_BELOW = 6;

	typedef enum logic [LEVEL_W-1:0] {
		LEVEL_NONE  = 2'd0,
		LEVEL_SHORT = 2'd1,
		LEVEL_MID   = 2'd2,
		LEVEL_LONG  = 2'd3
	} hold_level_t;

endpackage

>>> sv/bdhm_if.sv
interface bdhm_in_if;
	logic valid;
	logic ready;
	logic raw_level;

	modport source (output valid, output raw_level, input ready);
	modport sink (input valid, input raw_level, output ready);
endinterface

interface bdhm_out_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 steady_level;
	logic                                 press_pulse;
	logic                                 release_pulse;
	logic                                 shutdown_request;
	logic                                 multi_press_pulse;
	logic [bdhm_pkg::HOLD_OUT_W-1:0]      hold_periods;
	logic [bdhm_pkg::LEVEL_W-1:0]         hold_level;

	modport source (output valid, output steady_level, output press_pulse,
		output release_pulse, output shutdown_request, output multi_press_pulse,
		output hold_periods, output hold_level, input ready);
	modport sink (input valid, input steady_level, input press_pulse,
		input release_pulse, input shutdown_request, input multi_press_pulse,
		input hold_periods, input hold_level, output ready);
endinterface

interface bdhm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [bdhm_pkg::CFG_IDX_W-1:0]    index;
	logic [bdhm_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/button_debounce_hold_multipress.sv
// Debounced push button (active low, one sample per tick) with hold-period counting,
// long-hold shutdown request and multi-press detection. Every cycle can take one
// sample beat; its result beat appears in the output register in the next cycle, and
// the sample channel stays ready while that register is empty or being drained.
// Throughput is one beat per cycle while the result channel drains, set by the single
// state-update stage; all timers and counters advance only on accepted sample beats.
// Configuration writes are always ready; timer lengths apply at the next timer load.
module button_debounce_hold_multipress #(
	parameter int TIMER_WIDTH = bdhm_pkg::TIMER_WIDTH_DEF,
	parameter int COUNT_WIDTH = bdhm_pkg::COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	bdhm_in_if.sink       sample_ch,
	bdhm_out_if.source    result_ch,
	bdhm_cfg_if.sink      cfg
);
	import bdhm_pkg::*;

	localparam int LEN_W = (TIMER_WIDTH > CFG_DATA_W) ? TIMER_WIDTH : CFG_DATA_W;
	localparam int CMP_W = (COUNT_WIDTH > HOLD_OUT_W) ? COUNT_WIDTH : HOLD_OUT_W;
	localparam logic [TIMER_WIDTH-1:0] TMAX = '1;
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
	localparam logic [CMP_W-1:0] SHOW_MAX = CMP_W'((1 << HOLD_OUT_W) - 1);

	// zero acts as one tick, long values saturate at the timer range
	function automatic logic [TIMER_WIDTH-1:0] load_len(input logic [CFG_DATA_W-1:0] v);
		logic [LEN_W-1:0] t;
		t = LEN_W'(v);
		if (v == '0)
			t = LEN_W'(1);
		if (t > LEN_W'(TMAX))
			t = LEN_W'(TMAX);
		return TIMER_WIDTH'(t);
	endfunction

	// configuration
	logic [CFG_DATA_W-1:0] debounce_ticks_q, window_ticks_q, hold_ticks_q;
	logic [LIMIT_W-1:0]    shutdown_limit_q, multi_target_q;

	// button state
	logic                   steady_q, prev_q, cand_q;
	logic [TIMER_WIDTH-1:0] deb_left_q, hold_left_q, win_left_q;
	logic                   deb_armed_q, hold_armed_q, win_armed_q;
	logic [COUNT_WIDTH-1:0] hold_cnt_q, press_cnt_q;

	// next state
	logic                   steady_d, cand_d;
	logic [TIMER_WIDTH-1:0] deb_left_d, hold_left_d, win_left_d;
	logic                   deb_armed_d, hold_armed_d, win_armed_d;
	logic [COUNT_WIDTH-1:0] hold_cnt_d, press_cnt_d;
	logic                   press_d, release_d, shut_d, multi_d;
	logic [HOLD_OUT_W-1:0]  shown_d;
	hold_level_t            level_d;

	// result register
	logic                   out_valid_q;
	logic                   steady_out_q, press_q, release_q, shut_q, multi_q;
	logic [HOLD_OUT_W-1:0]  shown_q;
	hold_level_t            level_q;

	logic in_fire;

	assign sample_ch.ready = !out_valid_q || result_ch.ready;
	assign in_fire         = sample_ch.valid && sample_ch.ready;
	assign cfg.ready       = 1'b1;

	always_comb begin
		steady_d     = steady_q;
		cand_d       = cand_q;
		deb_left_d   = deb_left_q;
		deb_armed_d  = deb_armed_q;
		hold_left_d  = hold_left_q;
		hold_armed_d = hold_armed_q;
		win_left_d   = win_left_q;
		win_armed_d  = win_armed_q;
		hold_cnt_d   = hold_cnt_q;
		press_cnt_d  = press_cnt_q;
		press_d      = 1'b0;
		release_d    = 1'b0;
		shut_d       = 1'b0;
		multi_d      = 1'b0;

		// window expiry
		if (win_armed_q) begin
			if (win_left_q <= TIMER_WIDTH'(1)) begin
				win_armed_d = 1'b0;
				win_left_d  = '0;
				if (CMP_W'(press_cnt_q) == CMP_W'(multi_target_q))
					multi_d = 1'b1;
				press_cnt_d = '0;
			end else begin
				win_left_d = win_left_q - TIMER_WIDTH'(1);
			end
		end

		// hold tick
		if (hold_armed_q) begin
			if (hold_left_q <= TIMER_WIDTH'(1)) begin
				if (hold_cnt_q != CMAX)
					hold_cnt_d = hold_cnt_q + COUNT_WIDTH'(1);
				hold_left_d = load_len(hold_ticks_q);
			end else begin
				hold_left_d = hold_left_q - TIMER_WIDTH'(1);
			end
		end

		// debounce
		if (sample_ch.raw_level != prev_q) begin
			if (sample_ch.raw_level != steady_q) begin
				cand_d      = sample_ch.raw_level;
				deb_left_d  = load_len(debounce_ticks_q);
				deb_armed_d = 1'b1;
			end else begin
				deb_armed_d = 1'b0;
				deb_left_d  = '0;
			end
		end else if (deb_armed_q) begin
			if (deb_left_q <= TIMER_WIDTH'(1)) begin
				deb_armed_d = 1'b0;
				deb_left_d  = '0;
				steady_d    = cand_q;
				if (cand_q) begin
					release_d    = 1'b1;
					hold_armed_d = 1'b0;
					hold_left_d  = '0;
					if (CMP_W'(hold_cnt_d) > CMP_W'(shutdown_limit_q))
						shut_d = 1'b1;
					if (press_cnt_d == '0) begin
						win_left_d  = load_len(window_ticks_q);
						win_armed_d = 1'b1;
					end
					if (press_cnt_d != CMAX)
						press_cnt_d = press_cnt_d + COUNT_WIDTH'(1);
				end else begin
					press_d      = 1'b1;
					hold_cnt_d   = '0;
					hold_left_d  = load_len(hold_ticks_q);
					hold_armed_d = 1'b1;
				end
			end else begin
				deb_left_d = deb_left_q - TIMER_WIDTH'(1);
			end
		end

		if (CMP_W'(hold_cnt_d) > SHOW_MAX)
			shown_d = HOLD_OUT_W'(SHOW_MAX);
		else
			shown_d = HOLD_OUT_W'(hold_cnt_d);

		if (hold_cnt_d == '0)
			level_d = LEVEL_NONE;
		else if (hold_cnt_d < COUNT_WIDTH'(LEVEL_ONE_BELOW))
			level_d = LEVEL_SHORT;
		else if (hold_cnt_d < COUNT_WIDTH'(LEVEL_TWO_BELOW))
			level_d = LEVEL_MID;
		else
			level_d = LEVEL_LONG;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= DEBOUNCE_TICKS_RST;
			window_ticks_q   <= WINDOW_TICKS_RST;
			hold_ticks_q     <= HOLD_TICKS_RST;
			shutdown_limit_q <= SHUTDOWN_LIMIT_RST;
			multi_target_q   <= MULTI_TARGET_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg.data;
				REG_WINDOW_TICKS:   window_ticks_q   <= cfg.data;
				REG_HOLD_TICKS:     hold_ticks_q     <= cfg.data;
				REG_SHUTDOWN_LIMIT: shutdown_limit_q <= cfg.data[LIMIT_W-1:0];
				REG_MULTI_TARGET:   multi_target_q   <= cfg.data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steady_q     <= 1'b1;
			prev_q       <= 1'b1;
			cand_q       <= 1'b1;
			deb_left_q   <= '0;
			deb_armed_q  <= 1'b0;
			hold_left_q  <= '0;
			hold_armed_q <= 1'b0;
			win_left_q   <= '0;
			win_armed_q  <= 1'b0;
			hold_cnt_q   <= '0;
			press_cnt_q  <= '0;
		end else if (in_fire) begin
			steady_q     <= steady_d;
			prev_q       <= sample_ch.raw_level;
			cand_q       <= cand_d;
			deb_left_q   <= deb_left_d;
			deb_armed_q  <= deb_armed_d;
			hold_left_q  <= hold_left_d;
			hold_armed_q <= hold_armed_d;
			win_left_q   <= win_left_d;
			win_armed_q  <= win_armed_d;
			hold_cnt_q   <= hold_cnt_d;
			press_cnt_q  <= press_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded with each accepted sample beat
	always_ff @(posedge clk) begin
		if (in_fire) begin
			steady_out_q <= steady_d;
			press_q      <= press_d;
			release_q    <= release_d;
			shut_q       <= shut_d;
			multi_q      <= multi_d;
			shown_q      <= shown_d;
			level_q      <= level_d;
		end
	end

	assign result_ch.valid             = out_valid_q;
	assign result_ch.steady_level      = steady_out_q;
	assign result_ch.press_pulse       = press_q;
	assign result_ch.release_pulse     = release_q;
	assign result_ch.shutdown_request  = shut_q;
	assign result_ch.multi_press_pulse = multi_q;
	assign result_ch.hold_periods      = shown_q;
	assign result_ch.hold_level        = level_q;

endmodule

>>> tb/sv/button_debounce_hold_multipress_tb.sv
module button_debounce_hold_multipress_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bdhm_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 1800;
	localparam int PHASE_ITEMS   = 150;
	localparam int MAX_WAIT      = 5;

	// index with no register behind it, writes must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

	typedef struct packed {
		logic                  steady_level;
		logic                  press_pulse;
		logic                  release_pulse;
		logic                  shutdown_request;
		logic                  multi_press_pulse;
		logic [HOLD_OUT_W-1:0] hold_periods;
		hold_level_t           hold_level;
	} button_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	bdhm_in_if  sample_ch();
	bdhm_out_if result_ch();
	bdhm_cfg_if cfg_ch();

	button_debounce_hold_multipress dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg       (cfg_ch)
	);

	always #CLK_HALF clk = ~clk;

	// register copies
	logic [CFG_DATA_W-1:0] debounce_len, window_len, hold_len;
	logic [LIMIT_W-1:0]    shutdown_limit, multi_target;

	// button state
	logic                  steady_now, last_raw, cand_level;
	logic [CFG_DATA_W-1:0] settle_left, period_left, window_left;
	logic                  settle_armed, period_armed, window_open;
	logic [COUNT_WIDTH_DEF-1:0] periods_held, presses_seen;

	button_beat_t predicted_beats[$];
	int mismatches    = 0;
	int beats_checked = 0;
	int samples_sent  = 0;
	int cycle_count   = 0;
	bit idle_free     = 1'b0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("button_debounce_hold_multipress: mismatch");
			$finish;
		end
	end

	// a zero length acts as one tick
	function automatic logic [CFG_DATA_W-1:0] load_ticks(input logic [CFG_DATA_W-1:0] v);
		return (v == '0) ? CFG_DATA_W'(1) : v;
	endfunction

	// one tick: window expiry, then hold tick, then debounce
	function automatic button_beat_t step_button(input logic raw);
		button_beat_t beat;
		beat = '0;
		if (window_open) begin
			if (window_left <= 1) begin
				window_open = 1'b0;
				window_left = '0;
				if (presses_seen == multi_target)
					beat.multi_press_pulse = 1'b1;
				presses_seen = '0;
			end else begin
				window_left--;
			end
		end
		if (period_armed) begin
			if (period_left <= 1) begin
				if (periods_held != '1)
					periods_held++;
				period_left = load_ticks(hold_len);
			end else begin
				period_left--;
			end
		end
		if (raw != last_raw) begin
			if (raw != steady_now) begin
				cand_level   = raw;
				settle_left  = load_ticks(debounce_len);
				settle_armed = 1'b1;
			end else begin
				settle_armed = 1'b0;
				settle_left  = '0;
			end
		end else if (settle_armed) begin
			if (settle_left <= 1) begin
				settle_armed = 1'b0;
				settle_left  = '0;
				steady_now   = cand_level;
				if (steady_now) begin
					beat.release_pulse = 1'b1;
					period_armed = 1'b0;
					period_left  = '0;
					if (periods_held > shutdown_limit)
						beat.shutdown_request = 1'b1;
					if (presses_seen == '0) begin
						window_left = load_ticks(window_len);
						window_open = 1'b1;
					end
					if (presses_seen != '1)
						presses_seen++;
				end else begin
					beat.press_pulse = 1'b1;
					periods_held = '0;
					period_left  = load_ticks(hold_len);
					period_armed = 1'b1;
				end
			end else begin
				settle_left--;
			end
		end
		last_raw = raw;
		beat.steady_level = steady_now;
		beat.hold_periods = periods_held;
		if (periods_held == '0)
			beat.hold_level = LEVEL_NONE;
		else if (periods_held < LEVEL_ONE_BELOW)
			beat.hold_level = LEVEL_SHORT;
		else if (periods_held < LEVEL_TWO_BELOW)
			beat.hold_level = LEVEL_MID;
		else
			beat.hold_level = LEVEL_LONG;
		return beat;
	endfunction

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		mismatches++;
		$display("mismatch %s at beat %0d: got %0d want %0d", what, beats_checked, got_v,
			want_v);
	endtask

	task automatic check_beat();
		button_beat_t got, want;
		got.steady_level      = result_ch.steady_level;
		got.press_pulse       = result_ch.press_pulse;
		got.release_pulse     = result_ch.release_pulse;
		got.shutdown_request  = result_ch.shutdown_request;
		got.multi_press_pulse = result_ch.multi_press_pulse;
		got.hold_periods      = result_ch.hold_periods;
		got.hold_level        = hold_level_t'(result_ch.hold_level);
		if (predicted_beats.size() == 0) begin
			report_mismatch("result beat with nothing predicted", 1, 0);
		end else begin
			want = predicted_beats.pop_front();
			if (got.steady_level !== want.steady_level)
				report_mismatch("steady_level", int'(got.steady_level),
					int'(want.steady_level));
			if (got.press_pulse !== want.press_pulse)
				report_mismatch("press_pulse", int'(got.press_pulse),
					int'(want.press_pulse));
			if (got.release_pulse !== want.release_pulse)
				report_mismatch("release_pulse", int'(got.release_pulse),
					int'(want.release_pulse));
			if (got.shutdown_request !== want.shutdown_request)
				report_mismatch("shutdown_request", int'(got.shutdown_request),
					int'(want.shutdown_request));
			if (got.multi_press_pulse !== want.multi_press_pulse)
				report_mismatch("multi_press_pulse", int'(got.multi_press_pulse),
					int'(want.multi_press_pulse));
			if (got.hold_periods !== want.hold_periods)
				report_mismatch("hold_periods", int'(got.hold_periods),
					int'(want.hold_periods));
			if (got.hold_level !== want.hold_level)
				report_mismatch("hold_level", int'(got.hold_level), int'(want.hold_level));
		end
		beats_checked++;
	endtask

	// result side: random stall before each beat
	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = idle_free ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
			check_beat();
		end
	end

	task automatic send_level(input logic lvl);
		int gap;
		gap = idle_free ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.raw_level <= lvl;
		do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
		predicted_beats.push_back(step_button(sample_ch.raw_level));
		samples_sent++;
	endtask

	// hold off the sender until every predicted beat is back
	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		while (predicted_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] wdata);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= wdata;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		case (idx)
			REG_DEBOUNCE_TICKS: debounce_len   = wdata;
			REG_WINDOW_TICKS:   window_len     = wdata;
			REG_HOLD_TICKS:     hold_len       = wdata;
			REG_SHUTDOWN_LIMIT: shutdown_limit = wdata[LIMIT_W-1:0];
			REG_MULTI_TARGET:   multi_target   = wdata[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] deb,
			input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] hold,
			input logic [LIMIT_W-1:0] limit, input logic [LIMIT_W-1:0] target);
		wait_idle();
		write_reg(REG_DEBOUNCE_TICKS, deb);
		write_reg(REG_WINDOW_TICKS, win);
		write_reg(REG_HOLD_TICKS, hold);
		write_reg(REG_SHUTDOWN_LIMIT, CFG_DATA_W'(limit));
		write_reg(REG_MULTI_TARGET, CFG_DATA_W'(target));
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	// one press with bounce around it, sometimes too short or plain noise
	task automatic play_gesture();
		int pick, d, h, press_ticks, rest_ticks;
		d    = int'(load_ticks(debounce_len));
		h    = int'(load_ticks(hold_len));
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			repeat ($urandom_range(1, 8)) send_level(1'($urandom_range(0, 1)));
			return;
		end
		repeat ($urandom_range(0, 3)) send_level(1'($urandom_range(0, 1)));
		if (pick == 1)
			press_ticks = $urandom_range(1, d);
		else
			press_ticks = $urandom_range(d + 1, d + 1 + h * (int'(shutdown_limit) + 3));
		repeat (press_ticks) send_level(1'b0);
		repeat ($urandom_range(0, 3)) send_level(1'($urandom_range(0, 1)));
		if (pick < 7)
			rest_ticks = $urandom_range(d + 1, d + 6);
		else
			rest_ticks = $urandom_range(d + 1, int'(load_ticks(window_len)) + d + 10);
		repeat (rest_ticks) send_level(1'b1);
	endtask

	// reset settings: glitches shorter than the debounce time change nothing
	task automatic test_reset_glitches();
		send_level(1'b0);
		send_level(1'b1);
		send_level(1'b0);
		send_level(1'b0);
		send_level(1'b1);
		send_level(1'b1);
		send_level(1'b0);
		send_level(1'b1);
	endtask

	// zero lengths act as one tick, limit zero, target one
	task automatic test_shortest_lengths();
		apply_settings('0, '0, '0, '0, LIMIT_W'(1));
		repeat (5) send_level(1'b0);
		repeat (4) send_level(1'b1);
		repeat (2) send_level(1'b0);
		repeat (3) send_level(1'b1);
	endtask

	// longest timers, limit fifteen never exceeded, target fifteen
	task automatic test_longest_lengths();
		apply_settings('1, '1, '1, '1, '1);
		repeat (3) send_level(1'b0);
		repeat (2) send_level(1'b1);
	endtask

	task automatic test_random_gestures();
		logic [CFG_DATA_W-1:0] deb, win, hold;
		logic [LIMIT_W-1:0]    limit, target;
		int run_start, phase_start;
		run_start = samples_sent;
		while (samples_sent - run_start < RANDOM_ITEMS) begin
			deb    = CFG_DATA_W'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4));
			hold   = CFG_DATA_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
			win    = CFG_DATA_W'($urandom_range(8, 60));
			limit  = LIMIT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(14, 15) :
				$urandom_range(0, 5));
			target = LIMIT_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4));
			apply_settings(deb, win, hold, limit, target);
			idle_free   = ($urandom_range(0, 3) == 0);
			phase_start = samples_sent;
			while (samples_sent - phase_start < PHASE_ITEMS)
				play_gesture();
		end
		idle_free = 1'b0;
	endtask

	initial begin
		arst_n              <= 1'b0;
		sample_ch.valid     <= 1'b0;
		sample_ch.raw_level <= 1'b1;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= REG_DEBOUNCE_TICKS;
		cfg_ch.data         <= '0;
		debounce_len   = DEBOUNCE_TICKS_RST;
		window_len     = WINDOW_TICKS_RST;
		hold_len       = HOLD_TICKS_RST;
		shutdown_limit = SHUTDOWN_LIMIT_RST;
		multi_target   = MULTI_TARGET_RST;
		steady_now     = 1'b1;
		last_raw       = 1'b1;
		cand_level     = 1'b1;
		settle_left    = '0;
		settle_armed   = 1'b0;
		period_left    = '0;
		period_armed   = 1'b0;
		periods_held   = '0;
		presses_seen   = '0;
		window_left    = '0;
		window_open    = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_glitches();
		test_shortest_lengths();
		test_longest_lengths();
		test_random_gestures();

		wait_idle();
		if (mismatches == 0)
			$display("button_debounce_hold_multipress: match");
		else
			$display("button_debounce_hold_multipress: mismatch");
		$finish;
	end

endmodule
